@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a given clock and active-low reset.
`define CHK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("itoa port check failed");

// Same check on the house clock and reset names.
`define CHK_ASSERT_DEF(lbl, prop) `CHK_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

@@ rtl/itoa_pkg.sv @@
`default_nettype none

package itoa_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DIGIT_W   = 4;
  // binary bits shifted into the BCD register per conversion cycle
  localparam int unsigned STEP_BITS = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // upper bound on the decimal digits of a magnitude up to 2^(bits-1)
  function automatic int unsigned max_digits(input int unsigned bits);
    return (bits * 3 + 9) / 10;
  endfunction

  typedef enum logic [2:0] {
    CONV_IDLE = 3'b001,
    CONV_RUN  = 3'b010,
    CONV_DONE = 3'b100
  } conv_state_e;

endpackage

`default_nettype wire

@@ rtl/itoa_fifo.sv @@
`default_nettype none

module itoa_fifo #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output logic                  wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  rd_valid_o,
  input  wire logic             rd_ready_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/itoa_front.sv @@
`default_nettype none

module itoa_front #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic                       neg_o,
  output logic      [VALUE_BITS-1:0] mag_o
);

  // Unsigned magnitude: the most negative value negates to itself, which
  // read unsigned is exactly its magnitude.
  assign neg_o   = value_i[VALUE_BITS-1];
  assign mag_o   = neg_o ? (~value_i + VALUE_BITS'(1)) : value_i;
  assign valid_o = valid_i;
  assign ready_o = ready_i;

endmodule

`default_nettype wire

@@ rtl/itoa_conv.sv @@
`default_nettype none

module itoa_conv #(
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned NDIG      = itoa_pkg::max_digits(VALUE_BITS),
  localparam int unsigned BCD_W     = NDIG * itoa_pkg::DIGIT_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  in_neg_i,
  input  wire logic [VALUE_BITS-1:0] in_mag_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       out_neg_o,
  output logic      [BCD_W-1:0]      out_bcd_o
);

  localparam int unsigned DW    = itoa_pkg::DIGIT_W;
  localparam int unsigned NSTEP = (VALUE_BITS + itoa_pkg::STEP_BITS - 1) / itoa_pkg::STEP_BITS;
  localparam int unsigned PAD_W = NSTEP * itoa_pkg::STEP_BITS;
  localparam int unsigned CNT_W = $clog2(NSTEP);

  itoa_pkg::conv_state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d, bcd_s;
  logic [PAD_W-1:0]      bin_q, bin_d, bin_s;
  logic                  neg_q, neg_d;
  logic                  load;

  // Double dabble, several bits per cycle: adjust every digit, then shift.
  always_comb begin
    bcd_s = bcd_q;
    bin_s = bin_q;
    for (int s = 0; s < int'(itoa_pkg::STEP_BITS); s++) begin
      for (int d = 0; d < int'(NDIG); d++) begin
        if (bcd_s[d*DW +: DW] >= DW'(5)) begin
          bcd_s[d*DW +: DW] = bcd_s[d*DW +: DW] + DW'(3);
        end
      end
      {bcd_s, bin_s} = {bcd_s[BCD_W-2:0], bin_s, 1'b0};
    end
  end

  assign in_ready_o  = (state_q == itoa_pkg::CONV_IDLE) ||
                       ((state_q == itoa_pkg::CONV_DONE) && out_ready_i);
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == itoa_pkg::CONV_DONE);
  assign out_neg_o   = neg_q;
  assign out_bcd_o   = bcd_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bcd_d   = bcd_q;
    bin_d   = bin_q;
    neg_d   = neg_q;
    unique case (state_q)
      itoa_pkg::CONV_IDLE: begin
        if (load) begin
          state_d = itoa_pkg::CONV_RUN;
        end
      end
      itoa_pkg::CONV_RUN: begin
        bcd_d = bcd_s;
        bin_d = bin_s;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = itoa_pkg::CONV_DONE;
        end
      end
      itoa_pkg::CONV_DONE: begin
        if (out_ready_i) begin
          state_d = load ? itoa_pkg::CONV_RUN : itoa_pkg::CONV_IDLE;
        end
      end
      default: begin
        state_d = itoa_pkg::CONV_IDLE;
      end
    endcase
    if (load) begin
      bcd_d = '0;
      bin_d = PAD_W'(in_mag_i);
      neg_d = in_neg_i;
      cnt_d = CNT_W'(NSTEP - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::CONV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
    neg_q <= neg_d;
  end

endmodule

`default_nettype wire

@@ rtl/itoa_emit.sv @@
`default_nettype none

module itoa_emit #(
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned NDIG      = itoa_pkg::max_digits(VALUE_BITS),
  localparam int unsigned BCD_W     = NDIG * itoa_pkg::DIGIT_W
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        in_neg_i,
  input  wire logic [BCD_W-1:0]            in_bcd_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [itoa_pkg::CHAR_W-1:0] out_char_o,
  output logic                             out_last_o
);

  localparam int unsigned DW    = itoa_pkg::DIGIT_W;
  localparam int unsigned IDX_W = $clog2(NDIG);

  logic [NDIG-1:0][DW-1:0]       bcd_q, bcd_d, bcd_in;
  logic [IDX_W-1:0]              idx_q, idx_d, top_idx;
  logic                          busy_q, busy_d;
  logic                          minus_q, minus_d;
  logic                          ovalid_q, ovalid_d;
  logic [itoa_pkg::CHAR_W-1:0]   char_q, char_d;
  logic                          last_q, last_d;
  logic                          last_digit, advance, load;

  assign bcd_in = in_bcd_i;

  // Highest nonzero digit; an all-zero magnitude starts at digit zero.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < int'(NDIG); d++) begin
      if (bcd_in[d] != '0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  assign last_digit  = !minus_q && (idx_q == '0);
  assign advance     = busy_q && (!ovalid_q || out_ready_i);
  assign in_ready_o  = !busy_q || (advance && last_digit);
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  always_comb begin
    bcd_d    = bcd_q;
    idx_d    = idx_q;
    busy_d   = busy_q;
    minus_d  = minus_q;
    ovalid_d = ovalid_q;
    char_d   = char_q;
    last_d   = last_q;
    priority if (advance) begin
      ovalid_d = 1'b1;
      last_d   = last_digit;
      char_d   = minus_q ? itoa_pkg::CHAR_MINUS
                         : itoa_pkg::CHAR_ZERO + {4'b0, bcd_q[idx_q]};
      if (minus_q) begin
        minus_d = 1'b0;
      end else if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - IDX_W'(1);
      end
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
    if (load) begin
      busy_d  = 1'b1;
      minus_d = in_neg_i;
      idx_d   = top_idx;
      bcd_d   = bcd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      minus_q  <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      minus_q  <= minus_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii_top.sv @@
// Channel   Dir  Word                    Fields (lowest bit up)
// s_axis    in   one integer             tdata: value (VALUE_BITS, signed), zero pad
// m_axis    out  one ASCII character     tdata: character (8); tlast: last_char
//
// A number is converted in the double-dabble converter and then leaves as 1 to
// 11 characters at 32 bits, one character per cycle while m_axis_tready is high.
// Conversion of the next number overlaps emission of the current one.
// Reset clears all control state; no warm-up follows.
// Either side may stall: a short queue sits ahead of the converter and the
// output character is held in a register until taken.
`default_nettype none

module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FIFO_DEPTH = 2,
  localparam int unsigned IN_W      = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [IN_W-1:0] s_axis_tdata,   // value
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic      [7:0]      m_axis_tdata,   // character
  output logic                 m_axis_tlast
);

  localparam int unsigned NDIG  = itoa_pkg::max_digits(VALUE_BITS);
  localparam int unsigned BCD_W = NDIG * itoa_pkg::DIGIT_W;

  logic                  fr_valid, fr_ready, fr_neg;
  logic [VALUE_BITS-1:0] fr_mag;
  logic                  q_valid, q_ready;
  logic [VALUE_BITS:0]   q_data;
  logic                  cv_valid, cv_ready, cv_neg;
  logic [BCD_W-1:0]      cv_bcd;

  itoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .value_i (s_axis_tdata[VALUE_BITS-1:0]),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .neg_o   (fr_neg),
    .mag_o   (fr_mag)
  );

  itoa_fifo #(.WIDTH(VALUE_BITS + 1), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  ({fr_neg, fr_mag}),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  itoa_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_neg_i    (q_data[VALUE_BITS]),
    .in_mag_i    (q_data[VALUE_BITS-1:0]),
    .out_valid_o (cv_valid),
    .out_ready_i (cv_ready),
    .out_neg_o   (cv_neg),
    .out_bcd_o   (cv_bcd)
  );

  itoa_emit #(.VALUE_BITS(VALUE_BITS)) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cv_valid),
    .in_ready_o  (cv_ready),
    .in_neg_i    (cv_neg),
    .in_bcd_i    (cv_bcd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/itoa_chk.sv @@
`default_nettype none
`include "assert_macros.svh"

module itoa_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  localparam logic [7:0] CHAR_NINE = itoa_pkg::CHAR_ZERO + 8'd9;

  logic is_minus, is_zero, is_digit, took, took_last, took_minus;

  assign is_minus   = (m_axis_tdata == itoa_pkg::CHAR_MINUS);
  assign is_zero    = (m_axis_tdata == itoa_pkg::CHAR_ZERO);
  assign is_digit   = (m_axis_tdata >= itoa_pkg::CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE);
  assign took       = m_axis_tvalid && m_axis_tready;
  assign took_last  = took && m_axis_tlast;
  assign took_minus = took && is_minus;

  `CHK_ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `CHK_ASSERT_DEF(a_char_legal, m_axis_tvalid |-> is_digit || is_minus)
  `CHK_ASSERT_DEF(a_minus_not_last, m_axis_tvalid && is_minus |-> !m_axis_tlast)
  `CHK_ASSERT_DEF(a_minus_then_lead, took_minus |=> !m_axis_tvalid || (is_digit && !is_zero))
  `CHK_ASSERT_DEF(a_no_lead_zero, took_last |=> !(m_axis_tvalid && is_zero && !m_axis_tlast))

endmodule

bind signed_int_to_decimal_ascii_top itoa_chk u_itoa_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
